// ===== rtl/core/mro_pkg.sv =====
// ----------------------------------------------------------------------------
// mro_pkg
// Shared types and constants for the Mandelbrot reference orbit unit.
// ----------------------------------------------------------------------------
package mro_pkg;

    localparam int DEF_ORBIT_DEPTH = 4096;
    localparam int DEF_FRAC_BITS   = 28;

    localparam int WORD_W   = 32;
    localparam int PROD_W   = 64;
    localparam int LIMIT_W  = 13;
    localparam int INDEX_W  = 12;
    localparam int ESC_W    = 13;

    localparam int S_DATA_W = 80;   // c_re, c_im, read_index, padded to bytes
    localparam int M_DATA_W = 80;   // escape_count, z_re, z_im, padded
    localparam int M_USER_W = 2;    // entry_valid, orbit_ready

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd1024;

    localparam logic ACT_COMPUTE = 1'b0;
    localparam logic ACT_READ    = 1'b1;

    // Controller to datapath strobes
    typedef struct packed {
        logic load_c;   // latch c, clear z
        logic mul_en;   // register the three products
        logic upd_en;   // take z = z^2 + c
    } dp_ctrl_t;

    typedef struct packed {
        logic escaped;  // |z|^2 >= 4, valid in the update cycle
    } dp_stat_t;

endpackage

// ===== rtl/core/mro_orbit_mem.sv =====
// ----------------------------------------------------------------------------
// mro_orbit_mem
// Orbit store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mro_orbit_mem
    import mro_pkg::*;
#(
    parameter int ORBIT_DEPTH = DEF_ORBIT_DEPTH,
    parameter int ADDR_W      = $clog2(ORBIT_DEPTH)
)
(
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  logic [2*WORD_W-1:0]   wr_data,
    input  logic                  rd_en,
    input  logic [ADDR_W-1:0]     rd_addr,
    output logic [2*WORD_W-1:0]   rd_data
);

    logic [2*WORD_W-1:0] mem [ORBIT_DEPTH];
    logic [2*WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/mro_iter_dp.sv =====
// ----------------------------------------------------------------------------
// mro_iter_dp
// Iteration datapath: z registers, product registers, z^2 + c with
// floor shift and saturation, escape test.
// ----------------------------------------------------------------------------
module mro_iter_dp
    import mro_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic                     clk,
    input  dp_ctrl_t                 ctrl,
    input  logic signed [WORD_W-1:0] c_re,
    input  logic signed [WORD_W-1:0] c_im,
    output logic signed [WORD_W-1:0] z_re,
    output logic signed [WORD_W-1:0] z_im,
    output dp_stat_t                 stat
);

    // 4 needs 2*FRAC_BITS+2 bits above the product LSB
    localparam bit ESC_EN = (2 * FRAC_BITS + 2) < PROD_W;
    localparam int ESC_SH = ESC_EN ? (2 * FRAC_BITS + 2) : 0;

    logic signed [WORD_W-1:0] zx_reg, zy_reg, cx_reg, cy_reg;
    logic signed [PROD_W-1:0] sq_re_reg, sq_im_reg, cross_reg;

    logic signed [PROD_W-1:0] diff, shr_re, shr_im;
    logic signed [PROD_W:0]   sum_re, sum_im;
    logic [PROD_W-1:0]        mag;
    logic [WORD_W-1:0]        sat_re, sat_im;

    function automatic logic [WORD_W-1:0] sat_word(input logic signed [PROD_W:0] v);
        logic fits;
        fits = (v[PROD_W:WORD_W-1] == '0) || (v[PROD_W:WORD_W-1] == '1);
        if (fits)
            return v[WORD_W-1:0];
        else if (v[PROD_W])
            return {1'b1, {(WORD_W-1){1'b0}}};
        else
            return {1'b0, {(WORD_W-1){1'b1}}};
    endfunction

    always_ff @(posedge clk)
    begin
        if (ctrl.load_c)
        begin
            cx_reg <= c_re;
            cy_reg <= c_im;
            zx_reg <= '0;
            zy_reg <= '0;
        end
        else if (ctrl.upd_en)
        begin
            zx_reg <= sat_re;
            zy_reg <= sat_im;
        end
        if (ctrl.mul_en)
        begin
            sq_re_reg <= zx_reg * zx_reg;
            sq_im_reg <= zy_reg * zy_reg;
            cross_reg <= zx_reg * zy_reg;
        end
    end

    always_comb
    begin
        diff   = sq_re_reg - sq_im_reg;
        shr_re = diff >>> FRAC_BITS;
        shr_im = cross_reg >>> (FRAC_BITS - 1);   // 2*x*y
        sum_re = (PROD_W+1)'(shr_re) + (PROD_W+1)'(cx_reg);
        sum_im = (PROD_W+1)'(shr_im) + (PROD_W+1)'(cy_reg);
        sat_re = sat_word(sum_re);
        sat_im = sat_word(sum_im);
        mag    = sq_re_reg + sq_im_reg;            // both squares non-negative
    end

    assign stat.escaped = ESC_EN && ((mag >> ESC_SH) != '0);
    assign z_re = zx_reg;
    assign z_im = zy_reg;

endmodule

// ===== rtl/core/mro_ctrl.sv =====
// ----------------------------------------------------------------------------
// mro_ctrl
// Sequencer: handshakes, iteration counter, orbit writes, read lookup and
// the output word register.
// ----------------------------------------------------------------------------
module mro_ctrl
    import mro_pkg::*;
#(
    parameter int ORBIT_DEPTH = DEF_ORBIT_DEPTH,
    parameter int ADDR_W      = $clog2(ORBIT_DEPTH),
    parameter int CNT_W       = $clog2(ORBIT_DEPTH + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input stream
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  in_action,
    input  logic [INDEX_W-1:0]    in_index,
    // configuration
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [LIMIT_W-1:0]    cfg_data,
    // datapath
    output dp_ctrl_t              dp_ctrl,
    input  dp_stat_t              dp_stat,
    // orbit memory
    output logic                  mem_wr_en,
    output logic [ADDR_W-1:0]     mem_wr_addr,
    output logic                  mem_rd_en,
    output logic [ADDR_W-1:0]     mem_rd_addr,
    input  logic [2*WORD_W-1:0]   mem_rd_data,
    // output word
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [ESC_W-1:0]      out_escape,
    output logic [2*WORD_W-1:0]   out_z,
    output logic                  out_entry_valid,
    output logic                  out_orbit_ready
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_UPD  = 5'b00100,
        ST_FIN  = 5'b01000,
        ST_READ = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [LIMIT_W-1:0] limit_reg;
    logic [CNT_W-1:0]   lim_eff_reg, lim_eff_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [CNT_W-1:0]   wcount_reg, wcount_next;
    logic [ESC_W-1:0]   esc_store_reg, esc_store_next;
    logic               rdy_flag_reg, rdy_flag_next;
    logic               hit_reg, hit_next;

    logic               ov_reg, ov_next;
    logic [ESC_W-1:0]   oesc_reg, oesc_next;
    logic [2*WORD_W-1:0] oz_reg, oz_next;
    logic               oent_reg, oent_next;
    logic               ordy_reg, ordy_next;

    logic               accept, slot_free;
    logic [31:0]        idx_ext, n_ext, lim_ext;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;
    assign slot_free = !ov_reg || out_ready;

    assign idx_ext = 32'(in_index);
    assign n_ext   = 32'(n_reg);
    assign lim_ext = 32'(limit_reg);

    assign mem_rd_en   = accept && (in_action == ACT_READ);
    assign mem_rd_addr = idx_ext[ADDR_W-1:0];
    assign mem_wr_addr = n_reg[ADDR_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        lim_eff_next   = lim_eff_reg;
        n_next         = n_reg;
        wcount_next    = wcount_reg;
        esc_store_next = esc_store_reg;
        rdy_flag_next  = rdy_flag_reg;
        hit_next       = hit_reg;
        ov_next        = ov_reg && !out_ready;
        oesc_next      = oesc_reg;
        oz_next        = oz_reg;
        oent_next      = oent_reg;
        ordy_next      = ordy_reg;
        dp_ctrl        = '0;
        mem_wr_en      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_action == ACT_COMPUTE)
                    begin
                        dp_ctrl.load_c = 1'b1;
                        n_next         = '0;
                        wcount_next    = '0;
                        lim_eff_next   = (lim_ext > ORBIT_DEPTH) ?
                                         CNT_W'(ORBIT_DEPTH) : CNT_W'(limit_reg);
                        state_next     = ST_MUL;
                    end
                    else
                    begin
                        hit_next   = rdy_flag_reg && (idx_ext < 32'(wcount_reg));
                        state_next = ST_READ;
                    end
                end
            end
            ST_MUL:
            begin
                if (n_reg >= lim_eff_reg)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    mem_wr_en      = 1'b1;
                    dp_ctrl.mul_en = 1'b1;
                    wcount_next    = n_reg + CNT_W'(1);
                    state_next     = ST_UPD;
                end
            end
            ST_UPD:
            begin
                if (dp_stat.escaped)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    dp_ctrl.upd_en = 1'b1;
                    n_next         = n_reg + CNT_W'(1);
                    state_next     = ST_MUL;
                end
            end
            ST_FIN:
            begin
                if (slot_free)
                begin
                    esc_store_next = n_ext[ESC_W-1:0];
                    rdy_flag_next  = 1'b1;
                    ov_next        = 1'b1;
                    oesc_next      = n_ext[ESC_W-1:0];
                    oz_next        = '0;
                    oent_next      = 1'b0;
                    ordy_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_READ:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    oesc_next  = esc_store_reg;
                    oz_next    = hit_reg ? mem_rd_data : '0;
                    oent_next  = hit_reg;
                    ordy_next  = rdy_flag_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            limit_reg     <= LIMIT_RESET;
            wcount_reg    <= '0;
            esc_store_reg <= '0;
            rdy_flag_reg  <= 1'b0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wcount_reg    <= wcount_next;
            esc_store_reg <= esc_store_next;
            rdy_flag_reg  <= rdy_flag_next;
            ov_reg        <= ov_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lim_eff_reg <= lim_eff_next;
        n_reg       <= n_next;
        hit_reg     <= hit_next;
        oesc_reg    <= oesc_next;
        oz_reg      <= oz_next;
        oent_reg    <= oent_next;
        ordy_reg    <= ordy_next;
    end

    assign out_valid       = ov_reg;
    assign out_escape      = oesc_reg;
    assign out_z           = oz_reg;
    assign out_entry_valid = oent_reg;
    assign out_orbit_ready = ordy_reg;

endmodule

// ===== rtl/core/mandelbrot_reference_orbit_unit.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_reference_orbit_unit
// Mandelbrot reference orbit in signed fixed point, kept in an orbit memory.
// ----------------------------------------------------------------------------
// Usage
//   Input words on the s_axis group. tuser is the action: compute (0) runs
//   z = z^2 + c from z = 0 for the point in tdata, writing each z to the
//   orbit memory before its escape test; read (1) fetches the entry at
//   read_index. Every input word gives exactly one output word on m_axis.
//   cfg_valid/cfg_ready write iteration_limit; write it only when idle.
// Sequence
//   Read: the memory read is registered on accept, and the READ state
//   then loads the output register once it is free. Compute: each
//   iteration is a product state, with the orbit write, then an
//   update/escape state, until z escapes or the iteration limit (capped
//   at the orbit depth) is reached. One word is in work at a time; the
//   next is taken as soon as the previous one sits in the output register.
// Reset
//   Limit returns to 1024, no orbit is ready, escape count is zero. The
//   orbit memory is not cleared; entries past the written count are never
//   reported.
// Stall
//   An output word holds while m_axis_tready is low; a finished item waits
//   in its final state until the output register frees.
// ----------------------------------------------------------------------------
module mandelbrot_reference_orbit_unit
    import mro_pkg::*;
#(
    parameter int ORBIT_DEPTH = DEF_ORBIT_DEPTH,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // c_re [31:0], c_im [63:32], read_index [75:64], zero [79:76]
    input  logic [S_DATA_W-1:0]  s_axis_tdata,
    // action [0]
    input  logic [0:0]           s_axis_tuser,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // escape_count [12:0], z_re [44:13], z_im [76:45], zero [79:77]
    output logic [M_DATA_W-1:0]  m_axis_tdata,
    // entry_valid [0], orbit_ready [1]
    output logic [M_USER_W-1:0]  m_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [LIMIT_W-1:0]   cfg_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready
);

    localparam int ADDR_W = $clog2(ORBIT_DEPTH);
    localparam int CNT_W  = $clog2(ORBIT_DEPTH + 1);

    dp_ctrl_t                 dp_ctrl;
    dp_stat_t                 dp_stat;
    logic signed [WORD_W-1:0] z_re, z_im;
    logic                     mem_wr_en, mem_rd_en;
    logic [ADDR_W-1:0]        mem_wr_addr, mem_rd_addr;
    logic [2*WORD_W-1:0]      mem_rd_data;
    logic [ESC_W-1:0]         out_escape;
    logic [2*WORD_W-1:0]      out_z;
    logic                     out_entry_valid, out_orbit_ready;

    mro_ctrl #(
        .ORBIT_DEPTH (ORBIT_DEPTH),
        .ADDR_W      (ADDR_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_axis_tvalid),
        .in_ready        (s_axis_tready),
        .in_action       (s_axis_tuser[0]),
        .in_index        (s_axis_tdata[2*WORD_W +: INDEX_W]),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .dp_ctrl         (dp_ctrl),
        .dp_stat         (dp_stat),
        .mem_wr_en       (mem_wr_en),
        .mem_wr_addr     (mem_wr_addr),
        .mem_rd_en       (mem_rd_en),
        .mem_rd_addr     (mem_rd_addr),
        .mem_rd_data     (mem_rd_data),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_escape      (out_escape),
        .out_z           (out_z),
        .out_entry_valid (out_entry_valid),
        .out_orbit_ready (out_orbit_ready)
    );

    mro_iter_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk  (clk),
        .ctrl (dp_ctrl),
        .c_re (s_axis_tdata[0 +: WORD_W]),
        .c_im (s_axis_tdata[WORD_W +: WORD_W]),
        .z_re (z_re),
        .z_im (z_im),
        .stat (dp_stat)
    );

    // entry layout: im in the upper word, re in the lower
    mro_orbit_mem #(
        .ORBIT_DEPTH (ORBIT_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data ({z_im, z_re}),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign m_axis_tdata = {(M_DATA_W - ESC_W - 2*WORD_W)'(0), out_z, out_escape};
    assign m_axis_tuser = {out_orbit_ready, out_entry_valid};

endmodule

// ===== rtl/core/mro_checker.sv =====
// ----------------------------------------------------------------------------
// mro_checker
// Port-level checks for the orbit unit, bound to the top level.
// ----------------------------------------------------------------------------
module mro_checker
    import mro_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic [S_DATA_W-1:0]  s_axis_tdata,
    input logic [0:0]           s_axis_tuser,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [M_DATA_W-1:0]  m_axis_tdata,
    input logic [M_USER_W-1:0]  m_axis_tuser,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [LIMIT_W-1:0]   cfg_data,
    input logic                 cfg_valid,
    input logic                 cfg_ready
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output word changed while stalled");

    // a valid entry needs a ready orbit
    a_entry_needs_orbit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[1])
        else $error("entry valid without a ready orbit");

    // an invalid entry carries zero z
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata[M_DATA_W-1:ESC_W] == '0))
        else $error("non-zero z on an invalid entry");

    // no new input taken while the unit is iterating: at most one word in work
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == ACT_COMPUTE) |=>
            !s_axis_tready)
        else $error("input taken during a compute");

endmodule

bind mandelbrot_reference_orbit_unit mro_checker u_checker (.*);

// ===== tb/sv/orbit_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orbit_result_checker
// Watches the input, output and limit channels of the reference orbit unit.
// Keeps its own orbit memory and predicts one reply per input word, then
// compares every output word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module orbit_result_checker
    import mro_pkg::*;
#(
    parameter int ORBIT_DEPTH = DEF_ORBIT_DEPTH,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [S_DATA_W-1:0]  s_axis_tdata,
    input  logic [0:0]           s_axis_tuser,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [M_DATA_W-1:0]  m_axis_tdata,
    input  logic [M_USER_W-1:0]  m_axis_tuser,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [LIMIT_W-1:0]   cfg_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    output int                   fail_count,
    output int                   replies_waiting
);

    localparam int     RADIUS_SH = 2 * FRAC_BITS + 2;   // 4.0 in squared units
    localparam longint WORD_HI   = 64'sd2147483647;
    localparam longint WORD_LO   = -64'sd2147483648;
    localparam int     REPORT_MAX = 10;

    typedef struct packed {
        logic [ESC_W-1:0]  escape_count;
        logic [WORD_W-1:0] z_re;
        logic [WORD_W-1:0] z_im;
        logic              entry_valid;
        logic              orbit_ready;
    } orbit_reply_t;

    orbit_reply_t      replies_due [$];
    logic [WORD_W-1:0] trace_re [ORBIT_DEPTH];
    logic [WORD_W-1:0] trace_im [ORBIT_DEPTH];
    int unsigned       trace_len;
    logic [ESC_W-1:0]  escape_now;
    logic              orbit_done;
    logic [LIMIT_W-1:0] limit_now;

    function automatic longint clamp_word(longint v);
        if (v > WORD_HI)
            return WORD_HI;
        if (v < WORD_LO)
            return WORD_LO;
        return v;
    endfunction

    function automatic bit outside_radius(longint x, longint y);
        longint unsigned mag;
        mag = x * x + y * y;
        if (RADIUS_SH >= 64)
            return 1'b0;
        return mag >= (64'd1 << RADIUS_SH);
    endfunction

    // Iterate z = z^2 + c from zero, storing each z before its escape test
    function automatic void run_orbit(longint cx, longint cy);
        int unsigned cap;
        int unsigned n;
        bit          going;
        longint      zx;
        longint      zy;
        longint      nx;
        longint      ny;
        cap = 32'(limit_now);
        if (cap > ORBIT_DEPTH)
            cap = ORBIT_DEPTH;
        n = 0;
        zx = 0;
        zy = 0;
        going = 1'b1;
        trace_len = 0;
        while (going && n < cap)
        begin
            trace_re[n] = zx[WORD_W-1:0];
            trace_im[n] = zy[WORD_W-1:0];
            trace_len = n + 1;
            if (outside_radius(zx, zy))
                going = 1'b0;
            else
            begin
                // arithmetic shift floors towards minus infinity
                nx = ((zx * zx - zy * zy) >>> FRAC_BITS) + cx;
                ny = ((zx * zy) >>> (FRAC_BITS - 1)) + cy;
                zx = clamp_word(nx);
                zy = clamp_word(ny);
                n++;
            end
        end
        escape_now = n[ESC_W-1:0];
        orbit_done = 1'b1;
    endfunction

    function automatic orbit_reply_t predict_reply(logic [S_DATA_W-1:0] data, logic act);
        orbit_reply_t r;
        int unsigned  idx;
        r = '0;
        if (act == ACT_COMPUTE)
            run_orbit(longint'($signed(data[WORD_W-1:0])),
                      longint'($signed(data[2*WORD_W-1:WORD_W])));
        else
        begin
            idx = 32'(data[2*WORD_W+INDEX_W-1:2*WORD_W]);
            if (orbit_done && idx < trace_len)
            begin
                r.z_re        = trace_re[idx];
                r.z_im        = trace_im[idx];
                r.entry_valid = 1'b1;
            end
        end
        r.escape_count = escape_now;
        r.orbit_ready  = orbit_done;
        return r;
    endfunction

    function automatic void check_field(string name, logic [WORD_W-1:0] want,
                                        logic [WORD_W-1:0] got);
        if (want !== got)
        begin
            if (fail_count < REPORT_MAX)
                $display("mismatch %s: expected %h got %h at %0t", name, want, got, $time);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        orbit_reply_t want;
        if (!rst_n)
        begin
            replies_due.delete();
            trace_len       = 0;
            escape_now      = '0;
            orbit_done      = 1'b0;
            limit_now       = LIMIT_RESET;
            fail_count      = 0;
            replies_waiting = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                limit_now = cfg_data;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (replies_due.size() == 0)
                begin
                    if (fail_count < REPORT_MAX)
                        $display("unexpected output word %h user %b at %0t",
                                 m_axis_tdata, m_axis_tuser, $time);
                    fail_count++;
                end
                else
                begin
                    want = replies_due.pop_front();
                    check_field("escape_count", WORD_W'(want.escape_count),
                                WORD_W'(m_axis_tdata[ESC_W-1:0]));
                    check_field("z_re", want.z_re,
                                m_axis_tdata[ESC_W+WORD_W-1:ESC_W]);
                    check_field("z_im", want.z_im,
                                m_axis_tdata[ESC_W+2*WORD_W-1:ESC_W+WORD_W]);
                    check_field("entry_valid", WORD_W'(want.entry_valid),
                                WORD_W'(m_axis_tuser[0]));
                    check_field("orbit_ready", WORD_W'(want.orbit_ready),
                                WORD_W'(m_axis_tuser[1]));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                replies_due.push_back(predict_reply(s_axis_tdata, s_axis_tuser[0]));
            replies_waiting = replies_due.size();
        end
    end

endmodule

// ===== tb/sv/tb_mandelbrot_reference_orbit_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mandelbrot_reference_orbit_unit
// Drives compute and read words into the reference orbit unit under random
// stalls on both sides, over several iteration limits, and leaves the
// prediction and comparison to orbit_result_checker.
// ----------------------------------------------------------------------------
module tb_mandelbrot_reference_orbit_unit;
    import mro_pkg::*;

    localparam int ORBIT_DEPTH = DEF_ORBIT_DEPTH;
    localparam int FRAC_BITS   = DEF_FRAC_BITS;

    // Longest quiet stretch of a correct run is one full-depth orbit
    // plus stalls; allow several times that.
    localparam int WATCHDOG_CYCLES = 50000;
    localparam int SETTLE_CYCLES   = 20;
    localparam int RESET_CYCLES    = 10;
    localparam int PHASE_WORDS     = 17;
    localparam int NOISY_PHASES    = 6;

    // Q4.28 points used by the directed part
    localparam logic [WORD_W-1:0] Q_ZERO        = 32'h0000_0000;
    localparam logic [WORD_W-1:0] Q_ONE         = 32'h1000_0000;
    localparam logic [WORD_W-1:0] Q_MINUS_ONE   = 32'hF000_0000;
    localparam logic [WORD_W-1:0] Q_MINUS_TWO   = 32'hE000_0000;
    localparam logic [WORD_W-1:0] Q_MAX         = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] Q_MIN         = 32'h8000_0000;
    localparam logic [WORD_W-1:0] Q_QUARTER     = 32'h0400_0000;
    localparam logic [WORD_W-1:0] Q_JUST_OUT    = 32'h0428_F5C3;  // 0.26, slow escape
    localparam logic [WORD_W-1:0] Q_MINUS_3_4   = 32'hF400_0000;
    localparam logic [WORD_W-1:0] Q_TENTH       = 32'h0199_999A;

    // Random points mostly fall in the box [-2.25, 1] x [-1.5, 1.5]
    localparam logic [WORD_W-1:0] BOX_RE_LO   = 32'hDC00_0000;
    localparam logic [WORD_W-1:0] BOX_RE_SPAN = 32'h3400_0000;
    localparam logic [WORD_W-1:0] BOX_IM_LO   = 32'hE800_0000;
    localparam logic [WORD_W-1:0] BOX_IM_SPAN = 32'h3000_0000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic [S_DATA_W-1:0]  s_axis_tdata = '0;
    logic [0:0]           s_axis_tuser = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [M_DATA_W-1:0]  m_axis_tdata;
    logic [M_USER_W-1:0]  m_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [LIMIT_W-1:0]   cfg_data = '0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;

    int unsigned words_sent = 0;
    int unsigned words_back = 0;
    int          idle_cycles = 0;
    int          ready_gap = 0;
    bit          calm = 1'b0;     // no stalls on either side once set
    int          fail_count;
    int          replies_waiting;

    always #5 clk = ~clk;

    mandelbrot_reference_orbit_unit #(
        .ORBIT_DEPTH (ORBIT_DEPTH),
        .FRAC_BITS   (FRAC_BITS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_data      (cfg_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready)
    );

    orbit_result_checker #(
        .ORBIT_DEPTH (ORBIT_DEPTH),
        .FRAC_BITS   (FRAC_BITS)
    ) i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .cfg_data        (cfg_data),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .fail_count      (fail_count),
        .replies_waiting (replies_waiting)
    );

    // Output side back-pressure: random bursts with tready held low
    always @(negedge clk)
    begin
        if (ready_gap > 0)
        begin
            ready_gap     <= ready_gap - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            ready_gap     <= $urandom_range(0, 6);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
            words_back <= words_back + 1;
    end

    // Watchdog: any accepted word on any channel restarts the count
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_CYCLES)
        begin
            $display("FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic logic [S_DATA_W-1:0] pack_item(logic [WORD_W-1:0] re,
                                                      logic [WORD_W-1:0] im,
                                                      logic [INDEX_W-1:0] idx);
        return {{(S_DATA_W-2*WORD_W-INDEX_W){1'b0}}, idx, im, re};
    endfunction

    // Present one word; valid stays high afterwards unless the next call idles
    task automatic put_word(input logic act, input logic [S_DATA_W-1:0] data);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 2) == 0)
            gap = $urandom_range(1, 7);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= act;
        do @(posedge clk); while (!s_axis_tready);
        words_sent++;
    endtask

    // Unused fields carry random bits
    task automatic issue_compute(input logic [WORD_W-1:0] re, input logic [WORD_W-1:0] im);
        put_word(ACT_COMPUTE, pack_item(re, im, INDEX_W'($urandom())));
    endtask

    task automatic issue_read(input logic [INDEX_W-1:0] idx);
        put_word(ACT_READ, pack_item($urandom(), $urandom(), idx));
    endtask

    // Hold off the sender until every reply has come back
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (words_back != words_sent) @(posedge clk);
    endtask

    task automatic set_limit(input logic [LIMIT_W-1:0] lim);
        drain();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= lim;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One limit per phase; small limits dominate, full depth is rare
    task automatic random_phase(input int words);
        int                 kind;
        logic [LIMIT_W-1:0] lim;
        kind = $urandom_range(0, 9);
        if (kind == 0)
            lim = LIMIT_W'($urandom_range(1000, 8191));
        else if (kind <= 3)
            lim = LIMIT_W'($urandom_range(1, 8));
        else if (kind <= 8)
            lim = LIMIT_W'($urandom_range(9, 200));
        else
            lim = '0;
        set_limit(lim);
        repeat (words)
        begin
            if ($urandom_range(0, 4) < 2)
            begin
                if ($urandom_range(0, 3) == 0)
                    issue_compute($urandom(), $urandom());
                else
                    issue_compute(BOX_RE_LO + $urandom_range(0, BOX_RE_SPAN),
                                  BOX_IM_LO + $urandom_range(0, BOX_IM_SPAN));
            end
            else if ($urandom_range(0, 4) < 3)
                issue_read(INDEX_W'($urandom_range(0, 255)));
            else
                issue_read(INDEX_W'($urandom_range(0, 4095)));
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Reset limit of 1024 with c = 0: the orbit never leaves zero.
        // Reads stay inside entries already written since reset.
        issue_compute(Q_ZERO, Q_ZERO);
        issue_read(0);
        issue_read(1023);

        // Limit above the depth saturates; this fills the whole memory,
        // so every index is safe to read from here on.
        set_limit(13'd8191);
        issue_compute(Q_ZERO, Q_ZERO);
        issue_read(4095);
        issue_read(2048);

        // Zero limit: ready, nothing valid, old entries stay hidden
        set_limit(13'd0);
        issue_compute(Q_MINUS_TWO, Q_ZERO);
        issue_read(0);
        issue_read(4095);

        set_limit(13'd4096);
        issue_compute(Q_MAX, Q_MAX);
        issue_read(1);
        issue_read(2);
        issue_compute(Q_MIN, Q_MIN);
        issue_compute(Q_MINUS_TWO, Q_ZERO);     // lands exactly on the radius
        issue_read(1);
        issue_compute(Q_MINUS_ONE, Q_ZERO);     // period two, runs to the limit
        issue_compute(Q_QUARTER, Q_ZERO);       // cusp
        issue_compute(Q_ZERO, Q_ONE);           // pre-periodic, in the set
        issue_read(3);
        issue_compute(Q_MINUS_3_4, Q_TENTH);    // negative products, floored
        issue_read(5);
        issue_compute(Q_JUST_OUT, Q_ZERO);

        set_limit(13'd1);
        issue_compute(Q_ZERO, Q_ZERO);
        issue_read(0);
        issue_read(1);

        repeat (NOISY_PHASES) random_phase(PHASE_WORDS);

        // Final stretch runs at full rate on both sides
        calm = 1'b1;
        random_phase(PHASE_WORDS);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && replies_waiting == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== mandelbrot_reference_orbit_unit.f =====
rtl/core/mro_pkg.sv
rtl/core/mro_orbit_mem.sv
rtl/core/mro_iter_dp.sv
rtl/core/mro_ctrl.sv
rtl/core/mandelbrot_reference_orbit_unit.sv
rtl/core/mro_checker.sv
tb/sv/orbit_result_checker.sv
tb/sv/tb_mandelbrot_reference_orbit_unit.sv
